/* hw/rtl/rkc_pkg.sv */
// Shared types and constants of the relativistic kinematics converter.
package rkc_pkg;

    // Quantity selector carried with each input word.
    typedef enum logic [2:0] {
        OP_TOTAL = 3'd0,
        OP_KIN   = 3'd1,
        OP_MOM   = 3'd2,
        OP_RIG   = 3'd3,
        OP_CURV  = 3'd4,
        OP_BETA  = 3'd5,
        OP_INVB  = 3'd6,
        OP_UNDEF = 3'd7
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ERR_OK   = 3'd0,
        ERR_OP   = 3'd1,
        ERR_SIGN = 3'd2,
        ERR_DIV  = 3'd3,
        ERR_PHYS = 3'd4
    } t_err;

    // Configuration register indexes.
    typedef enum logic {
        REG_MASS   = 1'b0,
        REG_CHARGE = 1'b1
    } t_reg;

    localparam int CHARGE_W    = 5;
    localparam int MASS_RESET  = 61491;
    localparam int CHARGE_RESET = 1;

endpackage

/* hw/rtl/rkc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rkc_div #(
    parameter int NW = 33,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_sb
);

    logic          r_vld [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [SW-1:0] r_sb  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          s_vld;
        logic [NW-1:0] s_num;
        logic [NW-1:0] s_quo;
        logic [DW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [SW-1:0] s_sb;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_num = i_num;
            assign s_quo = '0;
            assign s_rem = '0;
            assign s_den = i_den;
            assign s_sb  = i_sb;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_num = r_num[k-1];
            assign s_quo = r_quo[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_sb  = r_sb[k-1];
        end

        // Bring down the next dividend bit and try one subtraction.
        assign trial = {s_rem, s_num[NW-1]};
        assign diff  = trial - {1'b0, s_den};
        assign take  = trial >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= s_num << 1;
                r_quo[k] <= {s_quo[NW-2:0], take};
                r_rem[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
                r_den[k] <= s_den;
                r_sb[k]  <= s_sb;
            end
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_quo = r_quo[NW-1];
    assign o_sb  = r_sb[NW-1];

endmodule

/* hw/rtl/rkc_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
module rkc_sqrt #(
    parameter int XW = 64,
    parameter int SW = 1,
    localparam int RW = XW / 2,
    localparam int EW = RW + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [XW-1:0] i_rad,
    input  logic [SW-1:0] i_sb,
    output logic          o_vld,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_sb
);

    logic          r_vld  [RW];
    logic [XW-1:0] r_rad  [RW];
    logic [EW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [SW-1:0] r_sb   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          s_vld;
        logic [XW-1:0] s_rad;
        logic [EW-1:0] s_rem;
        logic [RW-1:0] s_root;
        logic [SW-1:0] s_sb;
        logic [EW+1:0] cand;
        logic [EW+1:0] trial;
        logic [EW+1:0] diff;
        logic          take;

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rad  = i_rad;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_sb   = i_sb;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rad  = r_rad[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_sb   = r_sb[k-1];
        end

        // Bring down two radicand bits and test the next root bit.
        assign cand  = {s_rem, s_rad[XW-1:XW-2]};
        assign trial = (EW+2)'({s_root, 2'b01});
        assign diff  = cand - trial;
        assign take  = cand >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= s_rad << 2;
                r_rem[k]  <= take ? diff[EW-1:0] : cand[EW-1:0];
                r_root[k] <= {s_root[RW-2:0], take};
                r_sb[k]   <= s_sb;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_sb   = r_sb[RW-1];

endmodule

/* hw/rtl/relativistic_kinematics_converter.sv */
// Top level: converts one kinematic quantity of a particle into all seven.
//
//  Channel  | Direction | Word contents (lowest bits first)
//  ---------+-----------+--------------------------------------------------------
//  s_axis   | in        | tdata: given_value; tuser: op
//  m_axis   | out       | tdata: total, kinetic, momentum, rigidity, curvature,
//           |           |        beta, inverse beta; tuser: error_code
//  apb      | in/out    | particle_mass at word 0, particle_charge at word 1
//
// One word is taken every cycle unless a held output word stalls the pipe. The path
// runs through two square-root pipelines and three bit-per-stage divider pipelines
// in series.
// Reset is synchronous and clears only valid bits and the two registers.
// All stages advance together; a held output word freezes the whole pipe.
module relativistic_kinematics_converter #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int IDW  = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int OFW  = 6 * VALUE_WIDTH + FRAC_BITS,
    localparam int ODW  = ((OFW + 7) / 8) * 8,
    localparam int PDW  = (VALUE_WIDTH - 1 > 32) ? 64 : 32,
    localparam int ALSB = (PDW == 64) ? 3 : 2,
    localparam int AW   = ALSB + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [IDW-1:0] i_s_axis_tdata,   // given_value
    input  logic [2:0]     i_s_axis_tuser,   // op
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [ODW-1:0] o_m_axis_tdata,   // total, kinetic, momentum, rigidity,
                                             // curvature, beta, inverse beta
    output logic [2:0]     o_m_axis_tuser,   // error_code
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [AW-1:0]  paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready
);

    localparam int VW  = VALUE_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int MW  = VW - 1;
    localparam int BW  = FB + 1;
    localparam int QW  = rkc_pkg::CHARGE_W;
    localparam int XW  = 2 * VW + FB + 8;
    localparam int RAW = 2 * VW;
    localparam int NW1 = 2 * FB + 1;
    localparam int NW2 = (FB > MW) ? MW + FB : 2 * MW;
    localparam int NW3 = (2 * FB + QW > MW + FB) ? 2 * FB + QW : MW + FB;

    localparam logic [MW-1:0]  VMAX  = '1;
    localparam logic [VW-1:0]  ONE_V = VW'(1) << FB;
    localparam logic [BW-1:0]  ONE_B = BW'(1) << FB;
    localparam logic [RAW-1:0] ONE2  = RAW'(1) << (2 * FB);

    // Saturate a magnitude to the largest positive value.
    function automatic logic [MW-1:0] sat_m(input logic [XW-1:0] x);
        logic [MW-1:0] r;
        r = (x > XW'(VMAX)) ? VMAX : x[MW-1:0];
        return r;
    endfunction

    // Two's complement encoding of sign and saturated magnitude.
    function automatic logic [VW-1:0] enc(input logic neg, input logic [MW-1:0] mag);
        logic [VW-1:0] w;
        w = {1'b0, mag};
        return neg ? (~w + 1'b1) : w;
    endfunction

    // Sideband bundles between the arithmetic units.
    typedef struct packed {
        rkc_pkg::t_op  op;
        rkc_pkg::t_err err;
        logic [MW-1:0] edir;
        logic [MW-1:0] smag;
        logic          neg;
        logic          magz;
    } t_sb1;

    typedef struct packed {
        rkc_pkg::t_op  op;
        rkc_pkg::t_err err;
        logic          divf;
        logic [MW-1:0] edir;
        logic [MW-1:0] x;
    } t_sb2;

    typedef struct packed {
        rkc_pkg::t_op  op;
        rkc_pkg::t_err err;
        logic          divf;
        logic [MW-1:0] edir;
        logic [MW-1:0] esq;
    } t_sb3;

    typedef struct packed {
        rkc_pkg::t_err err;
        logic          divf;
        logic [MW-1:0] e;
        logic [MW-1:0] k;
    } t_sb4;

    typedef struct packed {
        rkc_pkg::t_err err;
        logic          divf;
        logic [MW-1:0] e;
        logic [MW-1:0] k;
        logic [MW-1:0] p;
    } t_sb5;

    // Configuration registers and pipe enable.
    logic [MW-1:0] r_mass;
    logic [QW-1:0] r_charge;
    logic          en;
    logic          qneg;
    logic          qz;
    logic [QW-1:0] qmag;
    rkc_pkg::t_reg reg_sel;

    assign reg_sel = rkc_pkg::t_reg'(paddr[AW-1]);
    assign pready  = 1'b1;
    assign qneg    = r_charge[QW-1];
    assign qz      = r_charge == '0;
    assign qmag    = qneg ? (~r_charge + 1'b1) : r_charge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass   <= MW'(rkc_pkg::MASS_RESET);
            r_charge <= QW'(rkc_pkg::CHARGE_RESET);
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                rkc_pkg::REG_MASS:   r_mass   <= pwdata[MW-1:0];
                rkc_pkg::REG_CHARGE: r_charge <= pwdata[QW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            rkc_pkg::REG_MASS:   prdata = PDW'(r_mass);
            rkc_pkg::REG_CHARGE: prdata = PDW'(r_charge);
            default:             prdata = '0;
        endcase
    end

    // Output register frees the pipe when empty or taken.
    logic r_o_vld;
    assign en              = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Stage 1: capture the input word.
    logic          r1_vld;
    rkc_pkg::t_op  r1_op;
    logic [VW-1:0] r1_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op  <= rkc_pkg::t_op'(i_s_axis_tuser);
            r1_raw <= i_s_axis_tdata[VW-1:0];
        end
    end

    // Stage 2: magnitude, range checks, direct energy for the energy inputs.
    logic          c2_neg;
    logic [VW-1:0] c2_mag;
    t_sb1          c2_sb;
    logic          r2_vld;
    t_sb1          r2_sb;
    logic [VW-1:0] r2_mag;

    assign c2_neg = r1_raw[VW-1];
    assign c2_mag = c2_neg ? (~r1_raw + 1'b1) : r1_raw;

    always_comb begin
        c2_sb.op   = r1_op;
        c2_sb.err  = rkc_pkg::ERR_OK;
        c2_sb.edir = '0;
        c2_sb.smag = sat_m(XW'(c2_mag));
        c2_sb.neg  = c2_neg;
        c2_sb.magz = c2_mag == '0;
        case (r1_op)
            rkc_pkg::OP_TOTAL: begin
                if (c2_neg || c2_mag < VW'(r_mass)) c2_sb.err = rkc_pkg::ERR_PHYS;
                c2_sb.edir = c2_sb.smag;
            end
            rkc_pkg::OP_KIN: begin
                if (c2_neg) c2_sb.err = rkc_pkg::ERR_PHYS;
                c2_sb.edir = sat_m(XW'(c2_sb.smag) + XW'(r_mass));
            end
            rkc_pkg::OP_BETA: begin
                if (c2_mag >= ONE_V) c2_sb.err = rkc_pkg::ERR_PHYS;
            end
            rkc_pkg::OP_INVB: begin
                if (c2_neg || c2_mag <= ONE_V) c2_sb.err = rkc_pkg::ERR_PHYS;
            end
            rkc_pkg::OP_UNDEF: c2_sb.err = rkc_pkg::ERR_OP;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sb  <= c2_sb;
            r2_mag <= c2_mag;
        end
    end

    // Divider 1: rigidity from curvature, 2^(2F) / |C|.
    logic                   d1_vld;
    logic [NW1-1:0]         d1_quo;
    logic [$bits(t_sb1)-1:0] d1_sbw;
    t_sb1                   d1_sb;

    rkc_div #(.NW(NW1), .DW(VW), .SW($bits(t_sb1))) u_div_curv_in (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r2_vld),
        .i_num  (NW1'(ONE2)),
        .i_den  (r2_sb.magz ? VW'(1) : r2_mag),
        .i_sb   (r2_sb),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_sb   (d1_sbw)
    );
    assign d1_sb = t_sb1'(d1_sbw);

    // Stage 3: rigidity to momentum, sign check, choose the value to square.
    logic             c3_isr;
    logic [MW-1:0]    c3_r;
    logic             c3_rneg;
    logic [MW+QW-1:0] c3_pm;
    t_sb2             c3_sb;
    logic             r3_vld;
    t_sb2             r3_sb;

    assign c3_isr  = d1_sb.op == rkc_pkg::OP_RIG || d1_sb.op == rkc_pkg::OP_CURV;
    assign c3_r    = (d1_sb.op == rkc_pkg::OP_RIG) ? d1_sb.smag :
                     (d1_sb.magz ? VMAX : sat_m(XW'(d1_quo)));
    assign c3_rneg = (d1_sb.op == rkc_pkg::OP_RIG) ? d1_sb.neg :
                     (!d1_sb.magz && d1_sb.neg);
    assign c3_pm   = (MW+QW)'(qmag) * (MW+QW)'(c3_r);

    always_comb begin
        c3_sb.op   = d1_sb.op;
        c3_sb.err  = d1_sb.err;
        c3_sb.divf = d1_sb.op == rkc_pkg::OP_CURV && d1_sb.magz;
        c3_sb.edir = d1_sb.edir;
        c3_sb.x    = c3_isr ? sat_m(XW'(c3_pm)) : d1_sb.smag;
        if (c3_isr && c3_pm != '0 && c3_rneg != qneg) c3_sb.err = rkc_pkg::ERR_SIGN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r3_sb <= c3_sb;
    end

    // Stage 4: squares of the value and of the mass.
    logic            r4_vld;
    t_sb2            r4_sb;
    logic [2*MW-1:0] r4_xx;
    logic [2*MW-1:0] r4_mm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sb <= r3_sb;
            r4_xx <= (2*MW)'(r3_sb.x) * (2*MW)'(r3_sb.x);
            r4_mm <= (2*MW)'(r_mass) * (2*MW)'(r_mass);
        end
    end

    // Stage 5: radicand of the first square root.
    logic           c5_isp;
    logic [RAW-1:0] c5_rad;
    logic           r5_vld;
    t_sb2           r5_sb;
    logic [RAW-1:0] r5_rad;

    assign c5_isp = r4_sb.op == rkc_pkg::OP_MOM || r4_sb.op == rkc_pkg::OP_RIG ||
                    r4_sb.op == rkc_pkg::OP_CURV;

    always_comb begin
        if (c5_isp) begin
            c5_rad = RAW'(r4_xx) + RAW'(r4_mm);
        end else if (r4_sb.op == rkc_pkg::OP_BETA) begin
            c5_rad = ONE2 - RAW'(r4_xx);
        end else if (r4_sb.op == rkc_pkg::OP_INVB) begin
            c5_rad = RAW'(r4_xx) - ONE2;
        end else begin
            c5_rad = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sb  <= r4_sb;
            r5_rad <= c5_rad;
        end
    end

    // Square root 1: energy from momentum, or the Lorentz denominator.
    logic                    s1_vld;
    logic [VW-1:0]           s1_root;
    logic [$bits(t_sb2)-1:0] s1_sbw;
    t_sb2                    s1_sb;

    rkc_sqrt #(.XW(RAW), .SW($bits(t_sb2))) u_sqrt_energy (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r5_vld),
        .i_rad  (r5_rad),
        .i_sb   (r5_sb),
        .o_vld  (s1_vld),
        .o_root (s1_root),
        .o_sb   (s1_sbw)
    );
    assign s1_sb = t_sb2'(s1_sbw);

    // Stage 6: numerator for the beta forms of the energy.
    logic [2*MW-1:0] c6_mx;
    t_sb3            c6_sb;
    logic            r6_vld;
    t_sb3            r6_sb;
    logic [NW2-1:0]  r6_num;
    logic [VW-1:0]   r6_den;

    assign c6_mx = (2*MW)'(r_mass) * (2*MW)'(s1_sb.x);

    always_comb begin
        c6_sb.op   = s1_sb.op;
        c6_sb.err  = s1_sb.err;
        c6_sb.divf = s1_sb.divf;
        c6_sb.edir = s1_sb.edir;
        c6_sb.esq  = sat_m(XW'(s1_root));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_sb  <= c6_sb;
            r6_num <= (s1_sb.op == rkc_pkg::OP_BETA) ? (NW2'(r_mass) << FB) : NW2'(c6_mx);
            r6_den <= (s1_root == '0) ? VW'(1) : s1_root;
        end
    end

    // Divider 2: energy from beta or inverse beta.
    logic                    d2_vld;
    logic [NW2-1:0]          d2_quo;
    logic [$bits(t_sb3)-1:0] d2_sbw;
    t_sb3                    d2_sb;

    rkc_div #(.NW(NW2), .DW(VW), .SW($bits(t_sb3))) u_div_energy (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r6_vld),
        .i_num  (r6_num),
        .i_den  (r6_den),
        .i_sb   (r6_sb),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_sb   (d2_sbw)
    );
    assign d2_sb = t_sb3'(d2_sbw);

    // Stage 7: pick the total energy and form E - m and E + m.
    logic [MW-1:0] c7_e;
    logic          r7_vld;
    t_sb4          r7_sb;
    logic [VW-1:0] r7_ep;

    always_comb begin
        case (d2_sb.op)
            rkc_pkg::OP_TOTAL, rkc_pkg::OP_KIN: c7_e = d2_sb.edir;
            rkc_pkg::OP_MOM, rkc_pkg::OP_RIG,
            rkc_pkg::OP_CURV:                   c7_e = d2_sb.esq;
            rkc_pkg::OP_BETA, rkc_pkg::OP_INVB: c7_e = sat_m(XW'(d2_quo));
            default:                            c7_e = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sb.err  <= d2_sb.err;
            r7_sb.divf <= d2_sb.divf;
            r7_sb.e    <= c7_e;
            r7_sb.k    <= (c7_e >= r_mass) ? c7_e - r_mass : '0;
            r7_ep      <= VW'(c7_e) + VW'(r_mass);
        end
    end

    // Stage 8: E^2 - m^2 as (E - m)(E + m).
    logic           r8_vld;
    t_sb4           r8_sb;
    logic [RAW-1:0] r8_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_sb   <= r7_sb;
            r8_prod <= RAW'(r7_sb.k) * RAW'(r7_ep);
        end
    end

    // Square root 2: momentum from the energy.
    logic                    s2_vld;
    logic [VW-1:0]           s2_root;
    logic [$bits(t_sb4)-1:0] s2_sbw;
    t_sb4                    s2_sb;

    rkc_sqrt #(.XW(RAW), .SW($bits(t_sb4))) u_sqrt_mom (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r8_vld),
        .i_rad  (r8_prod),
        .i_sb   (r8_sb),
        .o_vld  (s2_vld),
        .o_root (s2_root),
        .o_sb   (s2_sbw)
    );
    assign s2_sb = t_sb4'(s2_sbw);

    // Stage 9: saturate the momentum.
    logic r9_vld;
    t_sb5 r9_sb;
    logic r9_pz;
    logic r9_ez;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_sb.err  <= s2_sb.err;
            r9_sb.divf <= s2_sb.divf;
            r9_sb.e    <= s2_sb.e;
            r9_sb.k    <= s2_sb.k;
            r9_sb.p    <= sat_m(XW'(s2_root));
            r9_pz      <= s2_root == '0;
            r9_ez      <= s2_sb.e == '0;
        end
    end

    // Dividers 3 to 6: rigidity, curvature, inverse beta and beta.
    logic                    dr_vld;
    logic [NW3-1:0]          dr_quo;
    logic [$bits(t_sb5)-1:0] dr_sbw;
    t_sb5                    dr_sb;
    logic [NW3-1:0]          dc_quo;
    logic                    dc_pz;
    logic [NW3-1:0]          di_quo;
    logic                    di_ez;
    logic [NW3-1:0]          db_quo;
    logic                    db_qz;

    rkc_div #(.NW(NW3), .DW(QW), .SW($bits(t_sb5))) u_div_rig (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r9_vld),
        .i_num  (NW3'(r9_sb.p)),
        .i_den  (qz ? QW'(1) : qmag),
        .i_sb   (r9_sb),
        .o_vld  (dr_vld),
        .o_quo  (dr_quo),
        .o_sb   (dr_sbw)
    );
    assign dr_sb = t_sb5'(dr_sbw);

    rkc_div #(.NW(NW3), .DW(MW), .SW(1)) u_div_curv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r9_vld),
        .i_num  (NW3'(qmag) << (2 * FB)),
        .i_den  (r9_pz ? MW'(1) : r9_sb.p),
        .i_sb   (r9_pz),
        .o_vld  (),
        .o_quo  (dc_quo),
        .o_sb   (dc_pz)
    );

    rkc_div #(.NW(NW3), .DW(MW), .SW(1)) u_div_invb (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r9_vld),
        .i_num  (NW3'(r9_sb.e) << FB),
        .i_den  (r9_pz ? MW'(1) : r9_sb.p),
        .i_sb   (r9_ez),
        .o_vld  (),
        .o_quo  (di_quo),
        .o_sb   (di_ez)
    );

    rkc_div #(.NW(NW3), .DW(MW), .SW(1)) u_div_beta (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r9_vld),
        .i_num  (NW3'(r9_sb.p) << FB),
        .i_den  (r9_ez ? MW'(1) : r9_sb.e),
        .i_sb   (qz),
        .o_vld  (),
        .o_quo  (db_quo),
        .o_sb   (db_qz)
    );

    // Final stage: special cases, error code and the output register.
    logic          f_kill;
    logic          f_div;
    logic [VW-1:0] f_rig;
    logic [VW-1:0] f_curv;
    logic [MW-1:0] f_invb;
    logic [BW-1:0] f_beta;
    logic [2:0]    f_err;

    logic [VW-1:0] r_o_tot;
    logic [VW-1:0] r_o_kin;
    logic [VW-1:0] r_o_mom;
    logic [VW-1:0] r_o_rig;
    logic [VW-1:0] r_o_curv;
    logic [BW-1:0] r_o_beta;
    logic [MW-1:0] r_o_invb;
    logic [2:0]    r_o_err;

    assign f_kill = dr_sb.err != rkc_pkg::ERR_OK;
    assign f_div  = dr_sb.divf || db_qz || dc_pz || di_ez;
    assign f_rig  = db_qz ? enc(1'b0, VMAX) : enc(qneg, sat_m(XW'(dr_quo)));
    assign f_curv = dc_pz ? (db_qz ? '0 : enc(qneg, VMAX)) : enc(qneg, sat_m(XW'(dc_quo)));
    assign f_invb = dc_pz ? VMAX : sat_m(XW'(di_quo));
    assign f_beta = di_ez ? '0 :
                    ((XW'(db_quo) > XW'(ONE_B)) ? ONE_B : db_quo[BW-1:0]);
    assign f_err  = f_kill ? dr_sb.err : (f_div ? rkc_pkg::ERR_DIV : rkc_pkg::ERR_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= dr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_tot  <= f_kill ? '0 : VW'(dr_sb.e);
            r_o_kin  <= f_kill ? '0 : VW'(dr_sb.k);
            r_o_mom  <= f_kill ? '0 : VW'(dr_sb.p);
            r_o_rig  <= f_kill ? '0 : f_rig;
            r_o_curv <= f_kill ? '0 : f_curv;
            r_o_beta <= f_kill ? '0 : f_beta;
            r_o_invb <= f_kill ? '0 : f_invb;
            r_o_err  <= f_err;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = ODW'({r_o_invb, r_o_beta, r_o_curv, r_o_rig,
                                   r_o_mom, r_o_kin, r_o_tot});
    assign o_m_axis_tuser  = r_o_err;

endmodule
